### rtl/bcds_pkg.sv
`default_nettype none
package bcds_pkg;
  localparam int DIST_W = 20;
  localparam int CFG_W = 13;
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_STORE,
    ST_READ,
    ST_FETCH,
    ST_DIV,
    ST_EMIT
  } state_t;
endpackage
`default_nettype wire

### rtl/bcds_if.sv
`default_nettype none
interface bcds_box_if #(parameter int COORD_BITS = 12);
  logic valid;
  logic ready;
  logic [COORD_BITS-1:0] box_left;
  logic [COORD_BITS-1:0] box_right;
  logic [COORD_BITS-1:0] box_top;
  logic [COORD_BITS-1:0] box_bottom;
  logic final_box;
  modport source(output valid, box_left, box_right, box_top, box_bottom, final_box,
                 input ready);
  modport sink(input valid, box_left, box_right, box_top, box_bottom, final_box,
               output ready);
endinterface

interface bcds_score_if;
  logic valid;
  logic ready;
  logic [19:0] score;
  logic normalized;
  logic overflow;
  logic last_score;
  modport source(output valid, score, normalized, overflow, last_score, input ready);
  modport sink(input valid, score, normalized, overflow, last_score, output ready);
endinterface

interface bcds_cfg_if;
  logic valid;
  logic ready;
  logic [7:0] index;
  logic [12:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/box_center_distance_score.sv
`default_nettype none
// Each box passes from acceptance through square root in the shared unit (DIV_W/2
// steps, one root bit a cycle) and a store state before input is ready again.
// Emission: each score passes through a read, an operand fetch, a 48-step division
// through that same unit (skipped when unnormalized) and an emit state.
// Input is not ready meanwhile; a stalled output word extends the emit cycle.
// Reset (rst, synchronous) clears the run, restores 640x480; the store is not cleared.
module box_center_distance_score
  import bcds_pkg::*;
#(
  parameter int MAX_BOXES = 64,
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS = 8
) (
  input wire logic clk,
  input wire logic rst,
  bcds_box_if.sink box,
  bcds_score_if.source result,
  bcds_cfg_if.sink cfg
);
  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int SQ_W = 2*COORD_BITS + 2;
  localparam int RAD_W = ((SQ_W + 2*FRAC_BITS + 1) / 2) * 2;
  localparam int FULL = 100 * (2 ** FRAC_BITS);
  localparam int SC_W = 24;
  localparam int DIV_W = (RAD_W > 48) ? RAD_W : 48;

  state_t state, state_next;
  logic [CFG_W-1:0] image_width, image_height;
  logic [DIST_W-1:0] mem [MAX_BOXES];
  logic [DIST_W-1:0] rd;
  logic [CW-1:0] box_count;
  logic [CW-1:0] idx;
  logic [DIST_W-1:0] min_distance, max_distance;
  logic overflow_seen;
  logic fin;
  logic [DIST_W-1:0] d;
  logic rs_valid;
  logic [DIST_W-1:0] rs_score;
  logic rs_norm, rs_ovf, rs_last;

  // geometry
  logic signed [COORD_BITS+2:0] cx, cy, hx, hy, dx, dy;
  always_comb begin
    cx = (COORD_BITS+3)'($signed({3'b0, box.box_left}) +
         ($signed({3'b0, box.box_right}) - $signed({3'b0, box.box_left})) / 2);
    cy = (COORD_BITS+3)'($signed({3'b0, box.box_top}) +
         ($signed({3'b0, box.box_bottom}) - $signed({3'b0, box.box_top})) / 2);
    hx = $signed((COORD_BITS+3)'(image_width >> 1));
    hy = $signed((COORD_BITS+3)'(image_height >> 1));
    dx = hx - cx;
    dy = hy - cy;
  end

  // squared radius of the incoming word (computed combinationally from ports)
  logic [2*COORD_BITS+3:0] sq_in;
  logic [COORD_BITS+1:0] axi, ayi;
  always_comb begin
    axi = dx[COORD_BITS+2] ? (COORD_BITS+2)'(-dx) : (COORD_BITS+2)'(dx);
    ayi = dy[COORD_BITS+2] ? (COORD_BITS+2)'(-dy) : (COORD_BITS+2)'(dy);
    sq_in = (2*COORD_BITS+4)'(axi) * (2*COORD_BITS+4)'(axi) +
            (2*COORD_BITS+4)'(ayi) * (2*COORD_BITS+4)'(ayi);
  end

  logic ar_start, ar_div, ar_busy;
  logic [DIV_W-1:0] opa, opb;
  logic [DIV_W-1:0] ar_res;

  bcds_arith #(.RAD_W(DIV_W), .Q_W(DIV_W)) u_arith (
    .clk(clk), .rst(rst), .start(ar_start), .is_div(ar_div),
    .opa(opa), .opb(opb), .busy(ar_busy), .result(ar_res)
  );

  logic norm;
  assign norm = max_distance != min_distance;
  logic [DIST_W-1:0] off;
  assign off = (rd >= min_distance) ? rd - min_distance : '0;

  always_comb begin
    ar_start = 1'b0;
    ar_div = 1'b0;
    opa = '0;
    opb = '0;
    if (state == ST_IDLE && box.valid) begin
      ar_start = 1'b1;
    end
    if (state == ST_FETCH && norm) begin
      ar_start = 1'b1;
      ar_div = 1'b1;
      opa = DIV_W'(FULL) * DIV_W'(off);
      opb = DIV_W'(max_distance - min_distance);
    end
    if (!ar_div) begin
      opa = DIV_W'(sq_in) << (2*FRAC_BITS);
    end
  end

  assign d = (ar_res > DIV_W'(DIST_MAX)) ? DIST_MAX : ar_res[DIST_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (box.valid) state_next = ST_SQRT;
      ST_SQRT: if (!ar_busy) state_next = ST_STORE;
      ST_STORE: state_next = fin ? ST_READ : ST_IDLE;
      ST_READ: state_next = ST_FETCH;
      ST_FETCH: state_next = norm ? ST_DIV : ST_EMIT;
      ST_DIV: if (!ar_busy) state_next = ST_EMIT;
      ST_EMIT: if (!rs_valid || result.ready) state_next =
                 (idx == box_count) ? ST_IDLE : ST_READ;
      default: state_next = ST_IDLE;
    endcase
  end

  assign box.ready = state == ST_IDLE;
  assign cfg.ready = 1'b1;

  logic emit_go;
  assign emit_go = state == ST_EMIT && (!rs_valid || result.ready);
  logic [SC_W-1:0] q_sat;
  assign q_sat = (ar_res > DIV_W'(FULL)) ? SC_W'(FULL) : ar_res[SC_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      image_width <= CFG_W'(640);
      image_height <= CFG_W'(480);
      box_count <= '0;
      min_distance <= DIST_MAX;
      max_distance <= '0;
      overflow_seen <= 1'b0;
      idx <= '0;
      rs_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.index == REG_IMAGE_WIDTH) image_width <= cfg.data;
      if (cfg.valid && cfg.index == REG_IMAGE_HEIGHT) image_height <= cfg.data;
      if (emit_go) begin
        rs_valid <= 1'b1;
      end else if (result.ready) begin
        rs_valid <= 1'b0;
      end
      if (state == ST_STORE) begin
        if (box_count == CW'(MAX_BOXES)) begin
          overflow_seen <= 1'b1;
        end else begin
          box_count <= box_count + 1'b1;
          if (d < min_distance) min_distance <= d;
          if (d > max_distance) max_distance <= d;
        end
        idx <= '0;
      end
      if (state == ST_READ) idx <= idx + 1'b1;
      if (emit_go && idx == box_count) begin
        box_count <= '0;
        min_distance <= DIST_MAX;
        max_distance <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && box.valid) begin
      fin <= box.final_box;
    end
    if (state == ST_STORE && box_count != CW'(MAX_BOXES)) mem[box_count[AW-1:0]] <= d;
    if (state == ST_READ) rd <= mem[idx[AW-1:0]];
    if (emit_go) begin
      rs_score <= norm ? DIST_W'(SC_W'(FULL) - q_sat) : rd;
      rs_norm <= norm;
      rs_ovf <= overflow_seen;
      rs_last <= idx == box_count;
    end
  end

  assign result.valid = rs_valid;
  assign result.score = rs_score;
  assign result.normalized = rs_norm;
  assign result.overflow = rs_ovf;
  assign result.last_score = rs_last;

  assert property (@(posedge clk) disable iff (rst) box.ready |-> !ar_busy)
    else $error("arith busy while idle");
  assert property (@(posedge clk) disable iff (rst) box_count <= CW'(MAX_BOXES))
    else $error("count beyond store");
  assert property (@(posedge clk) disable iff (rst)
    (box_count != '0) |-> (min_distance <= max_distance))
    else $error("min above max");
endmodule
`default_nettype wire

### rtl/bcds_arith.sv
`default_nettype none
// Shared restoring unit: square root (one root bit a cycle) or
// division (one quotient bit a cycle). One operation at a time.
module bcds_arith
  import bcds_pkg::*;
#(
  parameter int RAD_W = 48,
  parameter int Q_W = 32
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic is_div,
  input wire logic [RAD_W-1:0] opa,
  input wire logic [RAD_W-1:0] opb,
  output logic busy,
  output logic [Q_W-1:0] result
);
  localparam int STEPS = (RAD_W > 2*Q_W) ? RAD_W : 2*Q_W;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int REM_W = RAD_W + 2;

  logic [CNT_W-1:0] cnt;
  logic [RAD_W-1:0] src;
  logic [REM_W-1:0] rem;
  logic [RAD_W-1:0] dvs;
  logic [Q_W-1:0] acc;
  logic mode;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic fits;

  function automatic logic [CNT_W-1:0] mode_steps(input logic d);
    mode_steps = d ? CNT_W'(RAD_W) : CNT_W'(RAD_W / 2);
  endfunction

  always_comb begin
    if (mode) begin
      rem_sh = {rem[REM_W-2:0], src[RAD_W-1]};
      trial = {2'b0, dvs};
    end else begin
      rem_sh = {rem[REM_W-3:0], src[RAD_W-1:RAD_W-2]};
      trial = REM_W'({acc, 2'b01});
    end
    fits = rem_sh >= trial;
  end

  assign busy = cnt != '0;
  assign result = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= mode_steps(is_div);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode <= is_div;
      src <= opa;
      dvs <= opb;
      rem <= '0;
      acc <= '0;
    end else if (busy) begin
      src <= mode ? {src[RAD_W-2:0], 1'b0} : {src[RAD_W-3:0], 2'b00};
      rem <= fits ? rem_sh - trial : rem_sh;
      acc <= {acc[Q_W-2:0], fits};
    end
  end
endmodule
`default_nettype wire
